// ===== design/segment_box_slab_test_unit_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef SEGMENT_BOX_SLAB_TEST_UNIT_MACROS_SVH
`define SEGMENT_BOX_SLAB_TEST_UNIT_MACROS_SVH

// Same-cycle implication.
`define SBST_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SBST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sbst_pkg.sv =====
package sbst_pkg;

	localparam int ENTRY_FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int MAG_W = DIFF_W;
	localparam int QUOT_BITS = ENTRY_FRAC_BITS + 2;
	localparam int T_W = QUOT_BITS + 1;
	localparam int ENTRY_W = ENTRY_FRAC_BITS + 1;
	localparam int REM_W = MAG_W + QUOT_BITS;
	localparam int AXES = 3;
	localparam int LANES = 2 * AXES;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [REM_W-1:0] rem_t;
	typedef logic [QUOT_BITS-1:0] quot_t;
	typedef logic signed [T_W-1:0] tval_t;
	typedef logic [ENTRY_W-1:0] frac_t;

	localparam quot_t QUOT_LIMIT = {2'b10, {ENTRY_FRAC_BITS{1'b0}}};
	localparam tval_t T_ONE = {3'b001, {ENTRY_FRAC_BITS{1'b0}}};
	localparam frac_t FRAC_ONE = {1'b1, {ENTRY_FRAC_BITS{1'b0}}};

	typedef struct packed {
		diff_t delta;
		diff_t off_lo;
		diff_t off_hi;
		logic flat;
	} axis_job_t;

	typedef struct packed {
		axis_job_t [AXES-1:0] axis;
		logic flat_miss;
	} job_t;

	typedef struct packed {
		rem_t rem;
		mag_t dvs;
		quot_t quo;
		logic sat;
		logic neg;
	} lane_t;

endpackage

// ===== design/sbst_if.sv =====
interface sbst_item_if;
	import sbst_pkg::*;
	logic valid;
	logic ready;
	coord_t start_x;
	coord_t start_y;
	coord_t start_z;
	coord_t end_x;
	coord_t end_y;
	coord_t end_z;
	coord_t box_min_x;
	coord_t box_min_y;
	coord_t box_min_z;
	coord_t box_max_x;
	coord_t box_max_y;
	coord_t box_max_z;

	modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface sbst_result_if;
	import sbst_pkg::*;
	logic valid;
	logic ready;
	logic hit;
	frac_t entry_fraction;

	modport source (output valid, hit, entry_fraction, input ready);
	modport sink (input valid, hit, entry_fraction, output ready);
endinterface

// ===== design/sbst_front.sv =====
module sbst_front (
	sbst_item_if.sink items,
	output sbst_pkg::job_t job,
	output logic job_valid,
	input logic job_ready
);
	import sbst_pkg::*;

	coord_t s [AXES];
	coord_t e [AXES];
	coord_t lo [AXES];
	coord_t hi [AXES];
	logic [AXES-1:0] outside;
	logic [AXES-1:0] flat;

	assign s[0] = items.start_x;
	assign s[1] = items.start_y;
	assign s[2] = items.start_z;
	assign e[0] = items.end_x;
	assign e[1] = items.end_y;
	assign e[2] = items.end_z;
	assign lo[0] = items.box_min_x;
	assign lo[1] = items.box_min_y;
	assign lo[2] = items.box_min_z;
	assign hi[0] = items.box_max_x;
	assign hi[1] = items.box_max_y;
	assign hi[2] = items.box_max_z;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			job.axis[a].delta = DIFF_W'(e[a]) - DIFF_W'(s[a]);
			job.axis[a].off_lo = DIFF_W'(lo[a]) - DIFF_W'(s[a]);
			job.axis[a].off_hi = DIFF_W'(hi[a]) - DIFF_W'(s[a]);
			flat[a] = (e[a] == s[a]);
			job.axis[a].flat = flat[a];
			outside[a] = (s[a] < lo[a]) || (s[a] > hi[a]);
		end
		// A segment with no extent on an axis can only miss through its start point.
		job.flat_miss = |(flat & outside);
	end

	assign job_valid = items.valid;
	assign items.ready = job_ready;

endmodule

// ===== design/sbst_queue.sv =====
module sbst_queue (
	input logic clk,
	input logic arst_n,
	input sbst_pkg::job_t wr_data,
	input logic wr_valid,
	output logic wr_ready,
	output sbst_pkg::job_t rd_data,
	output logic rd_valid,
	input logic rd_pop
);
	import sbst_pkg::*;

	job_t slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign wr_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_pop && rd_valid;
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== design/sbst_back.sv =====
`include "segment_box_slab_test_unit_macros.svh"

module sbst_back (
	input logic clk,
	input logic arst_n,
	input sbst_pkg::job_t job,
	input logic job_valid,
	output logic job_pop,
	sbst_result_if.source results
);
	import sbst_pkg::*;

	function automatic mag_t abs_mag(diff_t v);
		diff_t n;
		n = -v;
		return v[DIFF_W-1] ? mag_t'(n) : mag_t'(v);
	endfunction

	// One restoring step; the first step also flags quotients of 4.0 or more.
	function automatic lane_t div_step(lane_t l, int bitpos, logic first);
		rem_t trial;
		lane_t r;
		trial = rem_t'(l.dvs) << bitpos;
		r = l;
		if (first) begin
			r.sat = (l.rem >= (rem_t'(l.dvs) << QUOT_BITS));
		end
		if (l.rem >= trial) begin
			r.rem = l.rem - trial;
			r.quo = l.quo | (quot_t'(1) << bitpos);
		end
		return r;
	endfunction

	function automatic tval_t signed_quot(lane_t l);
		quot_t m;
		tval_t t;
		m = (l.sat || (l.quo > QUOT_LIMIT)) ? QUOT_LIMIT : l.quo;
		t = tval_t'({1'b0, m});
		return l.neg ? -t : t;
	endfunction

	logic en;

	lane_t abs_c [LANES];
	lane_t abs_s1 [LANES];
	logic [AXES-1:0] flat_s1;
	logic miss_s1;
	logic v_s1;

	lane_t div_s2 [QUOT_BITS][LANES];
	logic [AXES-1:0] div_flat_s2 [QUOT_BITS];
	logic div_miss_s2 [QUOT_BITS];
	logic [QUOT_BITS-1:0] div_v_s2;

	tval_t t0_c [AXES];
	tval_t t1_c [AXES];
	tval_t t0_s3 [AXES];
	tval_t t1_s3 [AXES];
	logic miss_s3;
	logic v_s3;

	tval_t near_c;
	tval_t far_c;
	logic hit_c;
	logic hit_s4;
	frac_t frac_s4;
	logic v_s4;

	assign en = !v_s4 || results.ready;
	assign job_pop = en && job_valid;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			for (int p = 0; p < 2; p++) begin
				diff_t off;
				off = p[0] ? job.axis[a].off_hi : job.axis[a].off_lo;
				abs_c[2*a+p].neg = off[DIFF_W-1] ^ job.axis[a].delta[DIFF_W-1];
				abs_c[2*a+p].rem = rem_t'(abs_mag(off)) << ENTRY_FRAC_BITS;
				abs_c[2*a+p].dvs = job.axis[a].flat ? mag_t'(1) : abs_mag(job.axis[a].delta);
				abs_c[2*a+p].quo = '0;
				abs_c[2*a+p].sat = 1'b0;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			tval_t ta;
			tval_t tb;
			ta = signed_quot(div_s2[QUOT_BITS-1][2*a]);
			tb = signed_quot(div_s2[QUOT_BITS-1][2*a+1]);
			if (div_flat_s2[QUOT_BITS-1][a]) begin
				// A flat axis that did not miss leaves the interval as it is.
				t0_c[a] = '0;
				t1_c[a] = T_ONE;
			end else if (ta > tb) begin
				t0_c[a] = tb;
				t1_c[a] = ta;
			end else begin
				t0_c[a] = ta;
				t1_c[a] = tb;
			end
		end
	end

	always_comb begin
		near_c = '0;
		far_c = T_ONE;
		for (int a = 0; a < AXES; a++) begin
			if (t0_s3[a] > near_c) begin
				near_c = t0_s3[a];
			end
			if (t1_s3[a] < far_c) begin
				far_c = t1_s3[a];
			end
		end
		hit_c = !miss_s3 && (near_c <= far_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			div_v_s2 <= '0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= job_valid;
			div_v_s2 <= {div_v_s2[QUOT_BITS-2:0], v_s1};
			v_s3 <= div_v_s2[QUOT_BITS-1];
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abs_s1 <= abs_c;
			for (int a = 0; a < AXES; a++) begin
				flat_s1[a] <= job.axis[a].flat;
			end
			miss_s1 <= job.flat_miss;

			for (int l = 0; l < LANES; l++) begin
				div_s2[0][l] <= div_step(abs_s1[l], QUOT_BITS - 1, 1'b1);
			end
			div_flat_s2[0] <= flat_s1;
			div_miss_s2[0] <= miss_s1;
			for (int k = 1; k < QUOT_BITS; k++) begin
				for (int l = 0; l < LANES; l++) begin
					div_s2[k][l] <= div_step(div_s2[k-1][l], QUOT_BITS - 1 - k, 1'b0);
				end
				div_flat_s2[k] <= div_flat_s2[k-1];
				div_miss_s2[k] <= div_miss_s2[k-1];
			end

			t0_s3 <= t0_c;
			t1_s3 <= t1_c;
			miss_s3 <= div_miss_s2[QUOT_BITS-1];

			hit_s4 <= hit_c;
			frac_s4 <= hit_c ? near_c[ENTRY_W-1:0] : '0;
		end
	end

	assign results.valid = v_s4;
	assign results.hit = hit_s4;
	assign results.entry_fraction = frac_s4;

	`SBST_ASSERT_IMPL(a_miss_zero, v_s4 && !hit_s4, frac_s4 == '0, "miss with nonzero fraction")
	`SBST_ASSERT_IMPL(a_frac_range, v_s4 && hit_s4, frac_s4 <= FRAC_ONE, "fraction above one")
	`SBST_ASSERT_NEXT(a_pipe_advance, v_s3 && en, v_s4, "transaction lost before output")

endmodule

// ===== design/segment_box_slab_test_unit.sv =====
// Channel   Dir  Payload
// items     in   start_x/y/z, end_x/y/z, box_min_x/y/z, box_max_x/y/z (signed Q24.8)
// results   out  hit, entry_fraction (Q1.16, 17 bits)
//
// One transaction per cycle sustained while results is ready; a queued item passes the input
// register, the 18-step pipelined divider on each of the six slab planes, then sort and reduce.
// A four-entry queue separates the input classifier from the divider pipeline.
// When results stalls, the whole back pipeline holds and items keeps accepting until the
// queue fills. Reset clears the queue and the pipeline valid bits only; no clearing pass.
module segment_box_slab_test_unit (
	input logic clk,
	input logic arst_n,
	sbst_item_if.sink items,
	sbst_result_if.source results
);
	import sbst_pkg::*;

	job_t front_job;
	logic front_valid;
	logic front_ready;
	job_t queue_job;
	logic queue_valid;
	logic queue_pop;

	sbst_front u_front (
		.items(items),
		.job(front_job),
		.job_valid(front_valid),
		.job_ready(front_ready)
	);

	sbst_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_data(front_job),
		.wr_valid(front_valid),
		.wr_ready(front_ready),
		.rd_data(queue_job),
		.rd_valid(queue_valid),
		.rd_pop(queue_pop)
	);

	sbst_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(queue_job),
		.job_valid(queue_valid),
		.job_pop(queue_pop),
		.results(results)
	);

endmodule
